### rtl/core/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg: shared constants for the topological sort engine
// Sizes of the vertex table and the edge store, the command codes and the sequencer codes.
// ----------------------------------------------------------------------------
package tse_pkg;
  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES    = 256;

  localparam int VID_W  = 6;                      // vertex id 0..32
  localparam int VIX_W  = $clog2(MAX_VERTICES);   // table index = id - 1
  localparam int EADR_W = $clog2(MAX_EDGES);      // edge store address
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);  // stored edge count
  localparam int DEG_W  = ECNT_W;                 // in-degree
  localparam int QCNT_W = $clog2(MAX_VERTICES + 1);

  // command carried in s_tuser
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  // sequencer states
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE = 3'd0;
  localparam logic [ST_W-1:0] S_SCAN = 3'd1;
  localparam logic [ST_W-1:0] S_DEQ  = 3'd2;
  localparam logic [ST_W-1:0] S_EDGE = 3'd3;
  localparam logic [ST_W-1:0] S_STAT = 3'd4;
endpackage

### rtl/core/tse_ram.sv
// ----------------------------------------------------------------------------
// tse_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/core/topological_sort_engine.sv
// ----------------------------------------------------------------------------
// topological_sort_engine: Kahn topological sort over a loaded edge list
// Edges are loaded into an edge store, a run walks it and streams the order.
// ----------------------------------------------------------------------------
// Input stream: s_tuser is the command (0 add edge, 1 run). An add beat is
// taken every cycle while idle; the edge is written to the edge store and
// the target's in-degree raised in the cycle it is accepted. Edges with an
// endpoint outside 1..min(vertex_count, 32), or arriving with the store
// full, are dropped and flagged for the next status beat.
// A run beat starts the sort; s_tready stays low until the run ends. The
// run scans vertices 1..n, places each vertex of a walk (the list head read
// overlaps it), follows its edge list one edge per cycle out of the edge store
// RAM, and ends each walk when it finds its queue empty.
// Output stream: one beat per placed vertex (m_tuser high), then a status
// beat with m_tlast high. A single output register parts the sides; placing
// a vertex and the status beat wait whenever it is full and not being taken.
// Reset empties the store and sets vertex_count to 32; after each run the
// store, in-degrees and visit marks are cleared in the status cycle. The
// user must write vertex_count via cfg_we/cfg_wdata while idle; not enforced.
// ----------------------------------------------------------------------------
module topological_sort_engine
  import tse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,     // vertex_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,       // [5:0] edge_source, [11:6] edge_target, zero fill
  input  logic        s_tuser,       // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,       // [5:0] vertex, [6] acyclic, [12:7] placed_count,
                                     // [13] edges_dropped, zero fill
  output logic        m_tuser,       // is_vertex
  output logic        m_tlast        // is_last
);
  // configuration
  logic [5:0]       vertex_count;
  logic [VID_W-1:0] n;

  // vertex table
  logic [DEG_W-1:0]  in_degree  [MAX_VERTICES];
  logic              visited    [MAX_VERTICES];
  logic              head_valid [MAX_VERTICES];
  logic [EADR_W-1:0] adj_head   [MAX_VERTICES];
  logic [EADR_W-1:0] adj_tail   [MAX_VERTICES];
  logic [VID_W-1:0]  ready_q    [MAX_VERTICES];

  logic [ECNT_W-1:0] edge_cnt;
  logic              drop_flag;

  // sequencer
  logic [ST_W-1:0]   state;
  logic [VID_W-1:0]  scan_v;
  logic [QCNT_W-1:0] qh, qt;
  logic [VID_W-1:0]  cur_u;
  logic [EADR_W-1:0] cur_e;
  logic [VID_W-1:0]  placed;

  // output register
  logic              ovalid;
  logic [VID_W-1:0]  o_vertex;
  logic              o_isv, o_last, o_acyc, o_drop;
  logic [VID_W-1:0]  o_placed;
  logic              can_emit;

  // input decode
  logic             in_acc;
  logic [VID_W-1:0] src, tgt;
  logic [VIX_W-1:0] src_ix, tgt_ix, scan_ix, u_ix, v_ix;
  logic             bad_edge, add_ok;

  // edge store ports
  logic              rd_en;
  logic [EADR_W-1:0] rd_addr;
  logic [VID_W-1:0]  tgt_rdata;
  logic [EADR_W-1:0] link_rdata;

  // walk helpers
  logic [VID_W-1:0]  deq_u;
  logic [DEG_W-1:0]  deg_dec;

  assign n        = (vertex_count > VID_W'(MAX_VERTICES)) ? VID_W'(MAX_VERTICES) : vertex_count;
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign src      = s_tdata[5:0];
  assign tgt      = s_tdata[11:6];
  assign src_ix   = VIX_W'(src - 1'b1);
  assign tgt_ix   = VIX_W'(tgt - 1'b1);
  assign scan_ix  = VIX_W'(scan_v - 1'b1);
  assign deq_u    = ready_q[qh[VIX_W-1:0]];
  assign u_ix     = VIX_W'(deq_u - 1'b1);
  assign v_ix     = VIX_W'(tgt_rdata - 1'b1);
  assign deg_dec  = (in_degree[v_ix] != '0) ? in_degree[v_ix] - 1'b1 : in_degree[v_ix];
  assign can_emit = !ovalid || m_tready;

  assign bad_edge = (src == '0) || (src > n) || (tgt == '0) || (tgt > n) ||
                    (edge_cnt >= ECNT_W'(MAX_EDGES));
  assign add_ok   = in_acc && (s_tuser == CMD_ADD) && !bad_edge;

  // edge store reads: list head on dequeue, next link while walking
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = link_rdata;
    unique case (state)
      S_DEQ: begin
        rd_en   = can_emit && (qh != qt) && head_valid[u_ix];
        rd_addr = adj_head[u_ix];
      end
      S_EDGE: begin
        rd_en   = (cur_e != adj_tail[cur_u[VIX_W-1:0] - 1'b1]);
        rd_addr = link_rdata;
      end
      default: begin
        rd_en   = 1'b0;
      end
    endcase
  end

  tse_ram #(.WIDTH(VID_W), .DEPTH(MAX_EDGES)) u_tgt_ram (
    .clk   (clk),
    .we    (add_ok),
    .waddr (edge_cnt[EADR_W-1:0]),
    .wdata (tgt),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (tgt_rdata)
  );

  tse_ram #(.WIDTH(EADR_W), .DEPTH(MAX_EDGES)) u_link_ram (
    .clk   (clk),
    .we    (add_ok && head_valid[src_ix]),
    .waddr (adj_tail[src_ix]),
    .wdata (edge_cnt[EADR_W-1:0]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 6'd32;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  // edge-list pointers and queue entries (no reset needed)
  always_ff @(posedge clk) begin
    if (add_ok) begin
      if (!head_valid[src_ix]) begin
        adj_head[src_ix] <= edge_cnt[EADR_W-1:0];
      end
      adj_tail[src_ix] <= edge_cnt[EADR_W-1:0];
    end
    if (state == S_SCAN && scan_v <= n && !visited[scan_ix] && in_degree[scan_ix] == '0) begin
      ready_q[0] <= scan_v;
    end
    if (state == S_EDGE && !visited[v_ix] && deg_dec == '0) begin
      ready_q[qt[VIX_W-1:0]] <= tgt_rdata;
    end
    if (rd_en) begin
      cur_e <= rd_addr;
    end
  end

  // sequencer and vertex table control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      edge_cnt  <= '0;
      drop_flag <= 1'b0;
      scan_v    <= '0;
      qh        <= '0;
      qt        <= '0;
      cur_u     <= '0;
      placed    <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        in_degree[i]  <= '0;
        visited[i]    <= 1'b0;
        head_valid[i] <= 1'b0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_tuser == CMD_RUN) begin
              state  <= S_SCAN;
              scan_v <= VID_W'(1);
              placed <= '0;
            end else if (bad_edge) begin
              drop_flag <= 1'b1;
            end else begin
              head_valid[src_ix] <= 1'b1;
              in_degree[tgt_ix]  <= in_degree[tgt_ix] + 1'b1;
              edge_cnt           <= edge_cnt + 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (scan_v > n) begin
            state <= S_STAT;
          end else if (visited[scan_ix] || in_degree[scan_ix] != '0) begin
            scan_v <= scan_v + 1'b1;
          end else begin
            visited[scan_ix] <= 1'b1;
            qh    <= '0;
            qt    <= QCNT_W'(1);
            state <= S_DEQ;
          end
        end
        S_DEQ: begin
          if (qh == qt) begin
            scan_v <= scan_v + 1'b1;
            state  <= S_SCAN;
          end else if (can_emit) begin
            qh     <= qh + 1'b1;
            cur_u  <= deq_u;
            placed <= placed + 1'b1;
            if (head_valid[u_ix]) begin
              state <= S_EDGE;
            end
          end
        end
        S_EDGE: begin
          if (!visited[v_ix]) begin
            in_degree[v_ix] <= deg_dec;
            if (deg_dec == '0) begin
              visited[v_ix] <= 1'b1;
              qt            <= qt + 1'b1;
            end
          end
          if (!rd_en) begin
            state <= S_DEQ;
          end
        end
        S_STAT: begin
          if (can_emit) begin
            state     <= S_IDLE;
            edge_cnt  <= '0;
            drop_flag <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
              in_degree[i]  <= '0;
              visited[i]    <= 1'b0;
              head_valid[i] <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == S_DEQ && qh != qt && can_emit) begin
      ovalid <= 1'b1;
    end else if (state == S_STAT && can_emit) begin
      ovalid <= 1'b1;
    end else if (m_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DEQ && qh != qt && can_emit) begin
      o_vertex <= deq_u;
      o_isv    <= 1'b1;
      o_last   <= 1'b0;
      o_acyc   <= 1'b0;
      o_placed <= '0;
      o_drop   <= 1'b0;
    end else if (state == S_STAT && can_emit) begin
      o_vertex <= '0;
      o_isv    <= 1'b0;
      o_last   <= 1'b1;
      o_acyc   <= (placed == n);
      o_placed <= placed;
      o_drop   <= drop_flag;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = {2'b00, o_drop, o_placed, o_acyc, o_vertex};
  assign m_tuser  = o_isv;
  assign m_tlast  = o_last;

  // checks
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ || state == S_EDGE) |-> (qh <= qt))
    else $error("ready queue head passed tail");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    edge_cnt <= ECNT_W'(MAX_EDGES))
    else $error("edge count beyond store size");

  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !m_tuser)
    else $error("status beat marked as vertex");

  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_STAT && can_emit) |=> (edge_cnt == '0 && state == S_IDLE))
    else $error("store not cleared after run");
endmodule
